@@ hdl/atfp_pkg.sv @@
// Package with the constants and types of the ASCII telemetry frame parser.
`timescale 1ns / 1ps

package atfp_pkg;

    localparam int MAX_FIELDS = 6;
    localparam int FIELD_COUNT_DEFAULT = 6;
    localparam int VALUE_WIDTH = 10;
    localparam int POS_WIDTH = 6;
    localparam int GROUP_WIDTH = 3;

    localparam logic [7:0] HDR_FIRST = 8'd86;
    localparam logic [7:0] HDR_SECOND = 8'd105;
    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_NINE = 8'd57;

    localparam logic [POS_WIDTH-1:0] FIRST_FRAME_POS = 6'd2;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        value_t [MAX_FIELDS-1:0] values;
        logic                    format_error;
    } result_t;

endpackage

@@ hdl/atfp_parser.sv @@
// Header hunt, frame position counter and digit accumulators of the frame parser.
`timescale 1ns / 1ps

module atfp_parser #(
    parameter int FIELD_COUNT = atfp_pkg::FIELD_COUNT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              result_valid,
    output atfp_pkg::result_t result
);

    localparam int LAST_OFFSET = 8 * (FIELD_COUNT - 1) + 6;

    logic                                            saw_v_reg;
    logic                                            saw_v_next;
    logic                                            in_frame_reg;
    logic                                            in_frame_next;
    logic [atfp_pkg::POS_WIDTH-1:0]                  position_reg;
    logic [atfp_pkg::POS_WIDTH-1:0]                  position_next;
    atfp_pkg::value_t [atfp_pkg::MAX_FIELDS-1:0]     values_reg;
    atfp_pkg::value_t [atfp_pkg::MAX_FIELDS-1:0]     values_next;
    atfp_pkg::value_t [atfp_pkg::MAX_FIELDS-1:0]     values_upd;
    logic                                            digit_error_reg;
    logic                                            digit_error_next;
    logic                                            error_upd;
    logic [atfp_pkg::GROUP_WIDTH-1:0]                grp;
    logic [2:0]                                      slot;
    logic                                            capture;
    logic                                            is_digit;
    logic [3:0]                                      digit;

    assign grp = position_reg[atfp_pkg::POS_WIDTH-1:3];
    assign slot = position_reg[2:0];
    assign capture = (slot == 3'd3) || (slot == 3'd5) || (slot == 3'd6);
    assign is_digit = (rx_byte >= atfp_pkg::ASCII_ZERO) && (rx_byte <= atfp_pkg::ASCII_NINE);
    assign digit = is_digit ? 4'(rx_byte - atfp_pkg::ASCII_ZERO) : 4'd0;

    // On a capture position the current group's field is multiplied by ten and the digit added, modulo the field width.
    always_comb
    begin
        values_upd = values_reg;
        error_upd = digit_error_reg;
        if (capture)
        begin
            for (int k = 0; k < atfp_pkg::MAX_FIELDS; k++)
            begin
                if ((k < FIELD_COUNT) && (grp == atfp_pkg::GROUP_WIDTH'(k)))
                begin
                    values_upd[k] = atfp_pkg::VALUE_WIDTH'({values_reg[k], 3'b000})
                                  + atfp_pkg::VALUE_WIDTH'({values_reg[k], 1'b0})
                                  + atfp_pkg::VALUE_WIDTH'(digit);
                end
            end
            if (!is_digit)
            begin
                error_upd = 1'b1;
            end
        end
    end

    always_comb
    begin
        saw_v_next = saw_v_reg;
        in_frame_next = in_frame_reg;
        position_next = position_reg;
        values_next = values_reg;
        digit_error_next = digit_error_reg;
        result_valid = 1'b0;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (saw_v_reg && (rx_byte == atfp_pkg::HDR_SECOND))
                begin
                    in_frame_next = 1'b1;
                    saw_v_next = 1'b0;
                    position_next = atfp_pkg::FIRST_FRAME_POS;
                    values_next = '0;
                    digit_error_next = 1'b0;
                end
                else
                begin
                    saw_v_next = (rx_byte == atfp_pkg::HDR_FIRST);
                end
            end
            else
            begin
                values_next = values_upd;
                digit_error_next = error_upd;
                if (position_reg >= atfp_pkg::POS_WIDTH'(LAST_OFFSET))
                begin
                    result_valid = 1'b1;
                    in_frame_next = 1'b0;
                    saw_v_next = 1'b0;
                    position_next = '0;
                end
                else
                begin
                    position_next = position_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < atfp_pkg::MAX_FIELDS; k++)
        begin
            result.values[k] = (k < FIELD_COUNT) ? values_upd[k] : '0;
        end
        result.format_error = error_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saw_v_reg <= 1'b0;
            in_frame_reg <= 1'b0;
            position_reg <= '0;
            values_reg <= '0;
            digit_error_reg <= 1'b0;
        end
        else
        begin
            saw_v_reg <= saw_v_next;
            in_frame_reg <= in_frame_next;
            position_reg <= position_next;
            values_reg <= values_next;
            digit_error_reg <= digit_error_next;
        end
    end

endmodule

@@ hdl/ascii_telemetry_frame_parser_top.sv @@
// A finished frame's result is registered in the output or skid register.
// Throughput: one byte per cycle while in_stall is low; the parser itself never stalls.
// A two-entry output stage (result register plus skid register) keeps bytes flowing
// while a result waits; in_stall rises only when both entries are full.
// Reset (rst_n, asynchronous, active low) returns the parser to header hunting with
// cleared accumulators and empties the output stage.
`timescale 1ns / 1ps

module ascii_telemetry_frame_parser_top #(
    parameter int FIELD_COUNT = atfp_pkg::FIELD_COUNT_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [9:0] input_voltage,
    output logic [9:0] output_voltage,
    output logic [9:0] input_power,
    output logic [9:0] input_current,
    output logic [9:0] output_current,
    output logic [9:0] reference_power,
    output logic       format_error
);

    logic              in_accept;
    logic              out_accept;
    logic              res_valid;
    atfp_pkg::result_t res;
    logic              out_valid_reg;
    logic              out_valid_next;
    atfp_pkg::result_t out_data_reg;
    atfp_pkg::result_t out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    atfp_pkg::result_t skid_data_reg;
    atfp_pkg::result_t skid_data_next;

    assign in_stall = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_accept = out_valid_reg && !out_stall;

    atfp_parser #(
        .FIELD_COUNT (FIELD_COUNT)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .rx_byte      (rx_byte),
        .result_valid (res_valid),
        .result       (res)
    );

    // A new result goes to the output register when it is free or being emptied,
    // otherwise to the skid register until the output transaction completes.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next = skid_data_reg;
        if (out_accept)
        begin
            out_valid_next = skid_valid_reg;
            out_data_next = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (res_valid)
        begin
            if (!out_valid_reg || out_accept)
            begin
                out_valid_next = 1'b1;
                out_data_next = res;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign input_voltage = out_data_reg.values[0];
    assign output_voltage = out_data_reg.values[1];
    assign input_power = out_data_reg.values[2];
    assign input_current = out_data_reg.values[3];
    assign output_current = out_data_reg.values[4];
    assign reference_power = out_data_reg.values[5];
    assign format_error = out_data_reg.format_error;

endmodule
